@@ sv/cql_pkg.sv @@
// Shared types, constants and decode functions for the congestion quality ladder.
package cql_pkg;

    // Widths of counters and fields
    localparam int TIMER_BITS = 24;
    localparam int STAT_BITS  = 32;
    localparam int LEVEL_W    = 4;
    localparam int RTT_W      = 16;
    localparam int BYTES_W    = 32;
    localparam int KB_W       = 22;
    localparam int DELAY_W    = 24;
    localparam int TILE_W     = 9;
    localparam int DS_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int KB_SHIFT   = 10;
    localparam int CMP_W      = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(8);

    // Request kinds on the input channel
    typedef enum logic [1:0] {
        REQ_METRICS = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_ADAPT   = 2'd2
    } req_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RTT_SPIKE      = 3'd0,
        CFG_RTT_RECOVERY   = 3'd1,
        CFG_CONGESTION_KB  = 3'd2,
        CFG_RECOVERY_KB    = 3'd3,
        CFG_DEGRADE_DELAY  = 3'd4,
        CFG_RECOVERY_DELAY = 3'd5,
        CFG_MAX_LEVEL      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [RTT_W-1:0]   rtt_spike_ms;
        logic [RTT_W-1:0]   rtt_recovery_ms;
        logic [KB_W-1:0]    congestion_kb;
        logic [KB_W-1:0]    recovery_kb;
        logic [DELAY_W-1:0] degrade_delay_ticks;
        logic [DELAY_W-1:0] recovery_delay_ticks;
        logic [LEVEL_W-1:0] max_level;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [RTT_W-1:0]   rtt_ms;
        logic [BYTES_W-1:0] backlog_bytes;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [TILE_W-1:0]    tile_edge;
        logic                 narrow_data;
        logic                 strong_compression;
        logic [DS_W-1:0]      downsample;
        logic                 changed;
        logic                 congested;
        logic [STAT_BITS-1:0] onset_count;
        logic [STAT_BITS-1:0] degrade_count;
        logic [STAT_BITS-1:0] improve_count;
    } result_t;

    // Tile edge for a level
    function automatic logic [TILE_W-1:0] tile_of(input logic [LEVEL_W-1:0] lv);
        logic [TILE_W-1:0] t;
        begin
            if (lv == LEVEL_W'(0))
                t = TILE_W'(256);
            else if (lv == LEVEL_W'(1))
                t = TILE_W'(192);
            else if (lv <= LEVEL_W'(6))
                t = TILE_W'(128);
            else
                t = TILE_W'(64);
            return t;
        end
    endfunction

    // Downsample step for a level
    function automatic logic [DS_W-1:0] ds_of(input logic [LEVEL_W-1:0] lv);
        logic [DS_W-1:0] d;
        begin
            if (lv <= LEVEL_W'(4))
                d = DS_W'(0);
            else if (lv == LEVEL_W'(5))
                d = DS_W'(1);
            else if (lv <= LEVEL_W'(7))
                d = DS_W'(2);
            else
                d = DS_W'(3);
            return d;
        end
    endfunction

endpackage

@@ sv/congestion_quality_ladder_top.sv @@
// Top level of the congestion quality ladder: input stage, ladder core, result register.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid / in_ready    | req_type, rtt_ms, backlog_bytes
//  out     | out_valid / out_ready  | level, tile_edge, narrow_data, ... improve_count
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while out_ready does not stall the output; an accepted request goes from
// the input register through one pass of compares and counter updates into the result register.
// Reset clears all ladder state and loads the default configuration; cfg_ready is always high.
// When out_ready is low the result register holds, the input register fills, then in_ready drops.
module congestion_quality_ladder_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [cql_pkg::RTT_W-1:0]      rtt_ms,
    input  logic [cql_pkg::BYTES_W-1:0]    backlog_bytes,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cql_pkg::LEVEL_W-1:0]    level,
    output logic [cql_pkg::TILE_W-1:0]     tile_edge,
    output logic                           narrow_data,
    output logic                           strong_compression,
    output logic [cql_pkg::DS_W-1:0]       downsample,
    output logic                           changed,
    output logic                           congested,
    output logic [cql_pkg::STAT_BITS-1:0]  onset_count,
    output logic [cql_pkg::STAT_BITS-1:0]  degrade_count,
    output logic [cql_pkg::STAT_BITS-1:0]  improve_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cql_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cql_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cql_pkg::*;

    cfg_t    cfg;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    item_fire;

    cql_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held request on when the result register is free or being drained
    assign advance   = !out_valid_reg || out_ready;
    assign item_fire = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;

    cql_ladder u_ladder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_fire (item_fire),
        .item      (s1_item_reg),
        .res       (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.req_type      <= req_type;
            s1_item_reg.rtt_ms        <= rtt_ms;
            s1_item_reg.backlog_bytes <= backlog_bytes;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            out_res_reg <= res;
        end
    end

    // Drive the result ports
    assign out_valid          = out_valid_reg;
    assign level              = out_res_reg.level;
    assign tile_edge          = out_res_reg.tile_edge;
    assign narrow_data        = out_res_reg.narrow_data;
    assign strong_compression = out_res_reg.strong_compression;
    assign downsample         = out_res_reg.downsample;
    assign changed            = out_res_reg.changed;
    assign congested          = out_res_reg.congested;
    assign onset_count        = out_res_reg.onset_count;
    assign degrade_count      = out_res_reg.degrade_count;
    assign improve_count      = out_res_reg.improve_count;

endmodule

@@ sv/cql_cfg_regs.sv @@
// Configuration register file for the congestion quality ladder.
module cql_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cql_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cql_pkg::CFG_DATA_W-1:0] cfg_data,
    output cql_pkg::cfg_t                  cfg
);
    import cql_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take a write request
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the index and merge the write data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RTT_SPIKE:      cfg_next.rtt_spike_ms         = cfg_data[RTT_W-1:0];
                CFG_RTT_RECOVERY:   cfg_next.rtt_recovery_ms      = cfg_data[RTT_W-1:0];
                CFG_CONGESTION_KB:  cfg_next.congestion_kb        = cfg_data[KB_W-1:0];
                CFG_RECOVERY_KB:    cfg_next.recovery_kb          = cfg_data[KB_W-1:0];
                CFG_DEGRADE_DELAY:  cfg_next.degrade_delay_ticks  = cfg_data[DELAY_W-1:0];
                CFG_RECOVERY_DELAY: cfg_next.recovery_delay_ticks = cfg_data[DELAY_W-1:0];
                CFG_MAX_LEVEL:      cfg_next.max_level            = cfg_data[LEVEL_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load defaults on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rtt_spike_ms         <= RTT_W'(200);
            cfg_reg.rtt_recovery_ms      <= RTT_W'(100);
            cfg_reg.congestion_kb        <= KB_W'(512);
            cfg_reg.recovery_kb          <= KB_W'(128);
            cfg_reg.degrade_delay_ticks  <= DELAY_W'(500);
            cfg_reg.recovery_delay_ticks <= DELAY_W'(2000);
            cfg_reg.max_level            <= TOP_LEVEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/cql_ladder.sv @@
// Ladder state, congestion detection, level stepping and result decode.
module cql_ladder (
    input  logic             clk,
    input  logic             rst_n,
    input  cql_pkg::cfg_t    cfg,
    input  logic             item_fire,
    input  cql_pkg::item_t   item,
    output cql_pkg::result_t res
);
    import cql_pkg::*;

    logic [LEVEL_W-1:0]    quality_level_reg, quality_level_next;
    logic                  congestion_flag_reg, congestion_flag_next;
    logic [RTT_W-1:0]      last_rtt_reg, last_rtt_next;
    logic [BYTES_W-1:0]    last_buffered_reg, last_buffered_next;
    logic [TIMER_BITS-1:0] ticks_degrade_reg, ticks_degrade_next;
    logic [TIMER_BITS-1:0] ticks_improve_reg, ticks_improve_next;
    logic [STAT_BITS-1:0]  edge_counter_reg, edge_counter_next;
    logic [STAT_BITS-1:0]  down_counter_reg, down_counter_next;
    logic [STAT_BITS-1:0]  up_counter_reg, up_counter_next;

    logic [LEVEL_W-1:0] ceiling;
    logic [BYTES_W-1:0] congest_bytes;
    logic [BYTES_W-1:0] recover_bytes;
    logic               now_congested;
    logic               degrade_ok;
    logic               improve_ok;
    logic               changed;

    // Clamp the ceiling and scale the kilobyte thresholds
    assign ceiling       = (cfg.max_level > TOP_LEVEL) ? TOP_LEVEL : cfg.max_level;
    assign congest_bytes = BYTES_W'(cfg.congestion_kb) << KB_SHIFT;
    assign recover_bytes = BYTES_W'(cfg.recovery_kb) << KB_SHIFT;
    assign now_congested = (item.rtt_ms > cfg.rtt_spike_ms) ||
                           (item.backlog_bytes > congest_bytes);

    // Step conditions on the stored state
    assign degrade_ok = (quality_level_reg < ceiling) && congestion_flag_reg;
    assign improve_ok = !degrade_ok && (quality_level_reg != '0) && !congestion_flag_reg &&
                        (last_rtt_reg < cfg.rtt_recovery_ms) &&
                        (last_buffered_reg < recover_bytes);

    // Next state for the request at hand
    always_comb
    begin
        quality_level_next   = quality_level_reg;
        congestion_flag_next = congestion_flag_reg;
        last_rtt_next        = last_rtt_reg;
        last_buffered_next   = last_buffered_reg;
        ticks_degrade_next   = ticks_degrade_reg;
        ticks_improve_next   = ticks_improve_reg;
        edge_counter_next    = edge_counter_reg;
        down_counter_next    = down_counter_reg;
        up_counter_next      = up_counter_reg;
        changed              = 1'b0;
        unique case (req_t'(item.req_type))
            REQ_METRICS:
            begin
                last_rtt_next        = item.rtt_ms;
                last_buffered_next   = item.backlog_bytes;
                congestion_flag_next = now_congested;
                if (now_congested && !congestion_flag_reg)
                    edge_counter_next = edge_counter_reg + STAT_BITS'(1);
            end
            REQ_TICK:
            begin
                if (ticks_degrade_reg != '1)
                    ticks_degrade_next = ticks_degrade_reg + TIMER_BITS'(1);
                if (ticks_improve_reg != '1)
                    ticks_improve_next = ticks_improve_reg + TIMER_BITS'(1);
            end
            REQ_ADAPT:
            begin
                if (degrade_ok &&
                    (CMP_W'(ticks_degrade_reg) >= CMP_W'(cfg.degrade_delay_ticks)))
                begin
                    quality_level_next = quality_level_reg + LEVEL_W'(1);
                    ticks_degrade_next = '0;
                    down_counter_next  = down_counter_reg + STAT_BITS'(1);
                    changed            = 1'b1;
                end
                else if (improve_ok &&
                    (CMP_W'(ticks_improve_reg) >= CMP_W'(cfg.recovery_delay_ticks)) &&
                    (CMP_W'(ticks_degrade_reg) >= CMP_W'(cfg.recovery_delay_ticks)))
                begin
                    quality_level_next = quality_level_reg - LEVEL_W'(1);
                    ticks_improve_next = '0;
                    up_counter_next    = up_counter_reg + STAT_BITS'(1);
                    changed            = 1'b1;
                end
            end
            default:
            begin
                changed = 1'b0;
            end
        endcase
    end

    // Decode the level after this request into the result
    always_comb
    begin
        res.level              = quality_level_next;
        res.tile_edge          = tile_of(quality_level_next);
        res.narrow_data        = (quality_level_next >= LEVEL_W'(3));
        res.strong_compression = (quality_level_next >= LEVEL_W'(4));
        res.downsample         = ds_of(quality_level_next);
        res.changed            = changed;
        res.congested          = congestion_flag_next;
        res.onset_count        = edge_counter_next;
        res.degrade_count      = down_counter_next;
        res.improve_count      = up_counter_next;
    end

    // Advance the state on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quality_level_reg   <= '0;
            congestion_flag_reg <= 1'b0;
            last_rtt_reg        <= '0;
            last_buffered_reg   <= '0;
            ticks_degrade_reg   <= '0;
            ticks_improve_reg   <= '0;
            edge_counter_reg    <= '0;
            down_counter_reg    <= '0;
            up_counter_reg      <= '0;
        end
        else if (item_fire)
        begin
            quality_level_reg   <= quality_level_next;
            congestion_flag_reg <= congestion_flag_next;
            last_rtt_reg        <= last_rtt_next;
            last_buffered_reg   <= last_buffered_next;
            ticks_degrade_reg   <= ticks_degrade_next;
            ticks_improve_reg   <= ticks_improve_next;
            edge_counter_reg    <= edge_counter_next;
            down_counter_reg    <= down_counter_next;
            up_counter_reg      <= up_counter_next;
        end
    end

`ifndef SYNTHESIS
    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        quality_level_reg <= TOP_LEVEL)
        else $error("quality level above top level");

    a_level_moves_on_adapt: assert property (@(posedge clk) disable iff (!rst_n)
        (quality_level_reg != $past(quality_level_reg)) |->
            ($past(item_fire) && ($past(item.req_type) == REQ_ADAPT)))
        else $error("level moved without an adapt request");

    a_degrade_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && changed && degrade_ok) |=> (ticks_degrade_reg == '0))
        else $error("degrade timer not cleared after step down");

    a_changed_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && changed) |=>
            ((down_counter_reg != $past(down_counter_reg)) ||
             (up_counter_reg != $past(up_counter_reg))))
        else $error("level change not counted");
`endif

endmodule
